@@ src/bccr_pkg.sv @@
// ---------------------------------------------------------------------------
// bccr_pkg
// shared types and constants for the button chord command recognizer
// ---------------------------------------------------------------------------
package bccr_pkg;

  localparam int BUTTON_COUNT_DEF = 8;
  localparam int MASK_MAX         = 8;
  localparam int ACT_W            = 3;
  localparam int IDX_W            = 3;
  localparam int ANIM_W           = 4;
  localparam int CFG_W            = 8;

  localparam logic [CFG_W-1:0]  CHORD_NINE_RST = 8'd3;
  localparam logic [CFG_W-1:0]  CHORD_TEN_RST  = 8'd129;
  localparam logic [ANIM_W-1:0] ANIM_NONE      = 4'd0;
  localparam logic [ANIM_W-1:0] ANIM_NINE      = 4'd9;
  localparam logic [ANIM_W-1:0] ANIM_TEN       = 4'd10;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK         = 3'd0,
    ACT_PRESS        = 3'd1,
    ACT_SINGLE_CLICK = 3'd2,
    ACT_SINGLE_HOLD  = 3'd3,
    ACT_DOUBLE_CLICK = 3'd4,
    ACT_DOUBLE_HOLD  = 3'd5,
    ACT_HOLD_END     = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    MSG_NONE        = 2'd0,
    MSG_PLAY_ONCE   = 2'd1,
    MSG_PLAY_REPEAT = 2'd2,
    MSG_END         = 2'd3
  } msg_kind_t;

  typedef enum logic [0:0] {
    REG_CHORD_NINE = 1'b0,
    REG_CHORD_TEN  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ src/bccr_front.sv @@
// ---------------------------------------------------------------------------
// bccr_front
// decodes an incoming event into an action code and a one-hot button mask
// ---------------------------------------------------------------------------
module bccr_front #(
  parameter int MASK_W = bccr_pkg::MASK_MAX
) (
  input  logic [7:0]              in_tdata,
  output bccr_pkg::act_t          act,
  output logic [MASK_W-1:0]       btn_mask
);
  import bccr_pkg::*;

  logic [IDX_W-1:0] idx;

  assign idx = in_tdata[ACT_W +: IDX_W];
  assign act = act_t'(in_tdata[ACT_W-1:0]);

  // buttons outside the mask width decode to an empty mask
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      btn_mask[i] = (idx == IDX_W'(i));
    end
  end

endmodule

@@ src/bccr_queue.sv @@
// ---------------------------------------------------------------------------
// bccr_queue
// two-entry queue between the decode front and the execute back
// ---------------------------------------------------------------------------
module bccr_queue #(
  parameter int W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        pop_data,
  output bccr_pkg::q_stat_t   stat
);
  import bccr_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

  a_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && stat.empty) |=> (count_r == 2'd0))
    else $error("pop on empty queue changed count");

endmodule

@@ src/bccr_back.sv @@
// ---------------------------------------------------------------------------
// bccr_back
// button tracking state, one event per cycle if not stalled, registered result
// ---------------------------------------------------------------------------
module bccr_back #(
  parameter int MASK_W = bccr_pkg::MASK_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  bccr_pkg::act_t                 q_act,
  input  logic [MASK_W-1:0]              q_mask,
  output logic                           q_pop,
  input  logic [bccr_pkg::CFG_W-1:0]     chord_nine,
  input  logic [bccr_pkg::CFG_W-1:0]     chord_ten,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata
);
  import bccr_pkg::*;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_WAIT   = 2'd2
  } mode_t;

  logic [MASK_W-1:0] pend_r, pend_nxt;
  logic [MASK_W-1:0] sclk_r, sclk_nxt;
  logic [MASK_W-1:0] shld_r, shld_nxt;
  logic [MASK_W-1:0] dclk_r, dclk_nxt;
  logic [MASK_W-1:0] dhld_r, dhld_nxt;
  logic [MASK_W-1:0] g0_r, g0_nxt;
  logic [MASK_W-1:0] g1_r, g1_nxt;
  logic [MASK_W-1:0] g2_r, g2_nxt;
  logic [MASK_W-1:0] g3_r, g3_nxt;
  mode_t             mode_r, mode_nxt;
  logic              gather_r, gather_nxt;
  logic              out_valid_r;
  msg_kind_t         kind_r, kind_nxt;
  logic [ANIM_W-1:0] anim_r, anim_nxt;

  logic [MASK_W-1:0] clicks, holds, chord, live_any;
  logic [CFG_W-1:0]  chord_ext;
  logic              has_hold, chord_onehot, lone_double, released;
  logic [ANIM_W-1:0] num;

  assign q_pop      = !q_empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, anim_r, kind_r};

  always_comb begin
    pend_nxt   = pend_r;
    sclk_nxt   = sclk_r;
    shld_nxt   = shld_r;
    dclk_nxt   = dclk_r;
    dhld_nxt   = dhld_r;
    g0_nxt     = g0_r;
    g1_nxt     = g1_r;
    g2_nxt     = g2_r;
    g3_nxt     = g3_r;
    mode_nxt   = mode_r;
    gather_nxt = gather_r;
    kind_nxt   = MSG_NONE;
    anim_nxt   = ANIM_NONE;

    live_any = sclk_r | shld_r | dclk_r | dhld_r;
    released = ((live_any | pend_r) == '0);

    // chord as it would be after folding in this tick's live masks
    lone_double  = ((g0_r | sclk_r) == '0) && ((g1_r | shld_r) == '0) &&
                   ((g3_r | dhld_r) == '0) && ((g2_r | dclk_r) != '0) &&
                   (((g2_r | dclk_r) & ((g2_r | dclk_r) - 1'b1)) == '0);
    clicks       = g0_r | sclk_r | g2_r | dclk_r;
    holds        = g1_r | shld_r | g3_r | dhld_r;
    has_hold     = (holds != '0);
    chord        = has_hold ? (clicks | holds) : clicks;
    chord_ext    = CFG_W'(chord);
    chord_onehot = (chord != '0) && ((chord & (chord - 1'b1)) == '0);

    num = ANIM_NONE;
    for (int i = 0; i < MASK_W; i++) begin
      if (chord_onehot && chord[i]) begin
        num = ANIM_W'(i + 1);
      end
    end
    if (num == ANIM_NONE && chord_ext == chord_nine) begin
      num = ANIM_NINE;
    end
    if (num == ANIM_NONE && chord_ext == chord_ten) begin
      num = ANIM_TEN;
    end

    unique case (q_act)
      ACT_TICK: begin
        if (mode_r == MODE_REPEAT || mode_r == MODE_WAIT) begin
          if (released) begin
            if (mode_r == MODE_REPEAT) begin
              kind_nxt = MSG_END;
            end
            pend_nxt   = '0;
            shld_nxt   = '0;
            dhld_nxt   = '0;
            g0_nxt     = '0;
            g1_nxt     = '0;
            g2_nxt     = '0;
            g3_nxt     = '0;
            mode_nxt   = MODE_NONE;
            gather_nxt = 1'b0;
          end
        end else begin
          g0_nxt     = g0_r | sclk_r;
          g1_nxt     = g1_r | shld_r;
          g2_nxt     = g2_r | dclk_r;
          g3_nxt     = g3_r | dhld_r;
          gather_nxt = gather_r || (live_any != '0);
          if (gather_nxt && pend_r == '0) begin
            if (lone_double || (num == ANIM_NONE && !has_hold) ||
                (num != ANIM_NONE && !has_hold)) begin
              if (num != ANIM_NONE && !lone_double) begin
                kind_nxt = MSG_PLAY_ONCE;
                anim_nxt = num;
              end
              pend_nxt   = '0;
              shld_nxt   = '0;
              dhld_nxt   = '0;
              g0_nxt     = '0;
              g1_nxt     = '0;
              g2_nxt     = '0;
              g3_nxt     = '0;
              mode_nxt   = MODE_NONE;
              gather_nxt = 1'b0;
            end else begin
              g0_nxt = clicks;
              g1_nxt = holds;
              if (num != ANIM_NONE) begin
                kind_nxt = MSG_PLAY_REPEAT;
                anim_nxt = num;
                mode_nxt = MODE_REPEAT;
              end else begin
                mode_nxt = MODE_WAIT;
              end
            end
          end
        end
        sclk_nxt = '0;
        dclk_nxt = '0;
      end
      ACT_PRESS: begin
        pend_nxt = pend_r | q_mask;
      end
      ACT_SINGLE_CLICK: begin
        pend_nxt = pend_r & ~q_mask;
        sclk_nxt = sclk_r | q_mask;
      end
      ACT_SINGLE_HOLD: begin
        pend_nxt = pend_r & ~q_mask;
        shld_nxt = shld_r | q_mask;
      end
      ACT_DOUBLE_CLICK: begin
        pend_nxt = pend_r & ~q_mask;
        dclk_nxt = dclk_r | q_mask;
      end
      ACT_DOUBLE_HOLD: begin
        pend_nxt = pend_r & ~q_mask;
        dhld_nxt = dhld_r | q_mask;
      end
      ACT_HOLD_END: begin
        shld_nxt = shld_r & ~q_mask;
        dhld_nxt = dhld_r & ~q_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      sclk_r      <= '0;
      shld_r      <= '0;
      dclk_r      <= '0;
      dhld_r      <= '0;
      g0_r        <= '0;
      g1_r        <= '0;
      g2_r        <= '0;
      g3_r        <= '0;
      mode_r      <= MODE_NONE;
      gather_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pend_r      <= pend_nxt;
        sclk_r      <= sclk_nxt;
        shld_r      <= shld_nxt;
        dclk_r      <= dclk_nxt;
        dhld_r      <= dhld_nxt;
        g0_r        <= g0_nxt;
        g1_r        <= g1_nxt;
        g2_r        <= g2_nxt;
        g3_r        <= g3_nxt;
        mode_r      <= mode_nxt;
        gather_r    <= gather_nxt;
        kind_r      <= kind_nxt;
        anim_r      <= anim_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_mode_needs_gather: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_REPEAT || mode_r == MODE_WAIT) |-> gather_r)
    else $error("active mode without a gathered chord");

  a_anim_only_on_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == MSG_NONE || kind_r == MSG_END)) |-> (anim_r == ANIM_NONE))
    else $error("animation number on a non-play message");

  a_repeat_enters_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && kind_nxt == MSG_PLAY_REPEAT) |=> (mode_r == MODE_REPEAT))
    else $error("play repeat sent without entering repeat mode");

endmodule

@@ src/button_chord_command_recognizer.sv @@
// ---------------------------------------------------------------------------
// button_chord_command_recognizer
// groups button clicks and holds into chords and issues animation commands
// ---------------------------------------------------------------------------
// an input transaction is written into the queue, then executed into the result
//   register, which drives out_tvalid
// throughput: one transaction per cycle while out_tready does not stall the execute stage
// output stalls are absorbed by the two-entry queue and the result register
// reset: synchronous active-low rst_n clears all tracking, the queue and the
//   result valid flag; chord registers return to 3 and 129
// ---------------------------------------------------------------------------
module button_chord_command_recognizer #(
  parameter int BUTTON_COUNT = bccr_pkg::BUTTON_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input event stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,    // action[2:0], button_index[5:3]
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,   // message_kind[1:0], anim_index[5:2]
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [bccr_pkg::CFG_W-1:0]  cfg_data
);
  import bccr_pkg::*;

  // only as many mask bits as the button index can address
  localparam int MASK_W = (BUTTON_COUNT < MASK_MAX) ? BUTTON_COUNT : MASK_MAX;
  localparam int Q_W    = ACT_W + MASK_W;

  logic [CFG_W-1:0]  chord_nine_r;
  logic [CFG_W-1:0]  chord_ten_r;

  act_t              fr_act;
  logic [MASK_W-1:0] fr_mask;
  logic [Q_W-1:0]    q_out;
  q_stat_t           q_stat;
  logic              q_pop;
  logic              in_xact;

  // configuration is taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chord_nine_r <= CHORD_NINE_RST;
      chord_ten_r  <= CHORD_TEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHORD_NINE: chord_nine_r <= cfg_data;
        REG_CHORD_TEN:  chord_ten_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: decode the event
  bccr_front #(
    .MASK_W(MASK_W)
  ) u_front (
    .in_tdata (in_tdata),
    .act      (fr_act),
    .btn_mask (fr_mask)
  );

  assign in_tready = !q_stat.full;
  assign in_xact   = in_tvalid && in_tready;

  // queue decouples decode from execute
  bccr_queue #(
    .W(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xact),
    .push_data ({fr_mask, fr_act}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // back: tracking state and result register
  bccr_back #(
    .MASK_W(MASK_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_stat.empty),
    .q_act      (act_t'(q_out[ACT_W-1:0])),
    .q_mask     (q_out[Q_W-1:ACT_W]),
    .q_pop      (q_pop),
    .chord_nine (chord_nine_r),
    .chord_ten  (chord_ten_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sim/tb_button_chord_command_recognizer.sv @@
// ---------------------------------------------------------------------------
// tb_button_chord_command_recognizer
// self-checking testbench: drives button event transactions, predicts the
// command for each one and compares it with every result transaction
// ---------------------------------------------------------------------------
module tb_button_chord_command_recognizer;
  import bccr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT = 29;
  // action code outside the defined set, must be ignored by the block
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_REPEAT = 2'd1,
    MODE_WAIT   = 2'd2
  } play_mode_t;

  typedef struct {
    msg_kind_t         kind;
    logic [ANIM_W-1:0] anim;
  } command_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;   // action[2:0], button_index[5:3]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;       // message_kind[1:0], anim_index[5:2]
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [0:0]       cfg_index = REG_CHORD_NINE;
  logic [CFG_W-1:0] cfg_data = '0;

  // idling control; quiet is shared by both sides, stall_left is for the result side only
  bit quiet = 1'b0;
  int stall_left = 0;

  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;

  command_t expected_commands[$];

  // predictor copy of the chord registers and of the tracking state
  logic [7:0] nine_sel = CHORD_NINE_RST;
  logic [7:0] ten_sel = CHORD_TEN_RST;
  logic [7:0] pend_mask = '0;
  logic [7:0] click1_mask = '0;
  logic [7:0] hold1_mask = '0;
  logic [7:0] click2_mask = '0;
  logic [7:0] hold2_mask = '0;
  logic [7:0] chord_acc[4] = '{default: '0};
  play_mode_t play_mode = MODE_IDLE;
  logic       gathering = 1'b0;

  button_chord_command_recognizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // command predictor
  // ---------------------------------------------------------------------------

  // drop every mask and go back to idle
  function automatic void clear_tracking();
    pend_mask = '0;
    click1_mask = '0;
    hold1_mask = '0;
    click2_mask = '0;
    hold2_mask = '0;
    for (int i = 0; i < 4; i++) chord_acc[i] = '0;
    play_mode = MODE_IDLE;
    gathering = 1'b0;
  endfunction

  function automatic void predict_command(input logic [ACT_W-1:0] act,
                                          input logic [IDX_W-1:0] idx,
                                          output command_t cmd);
    logic [7:0] btn;
    logic [7:0] clicks;
    logic [7:0] holds;
    logic [7:0] chord;
    logic       hold;
    cmd.kind = MSG_NONE;
    cmd.anim = ANIM_NONE;
    btn = 8'd1 << idx;
    case (act)
      ACT_TICK: begin
        if (play_mode == MODE_REPEAT || play_mode == MODE_WAIT) begin
          // leave the play state only once everything is let go
          if ((click1_mask | hold1_mask | click2_mask | hold2_mask | pend_mask) == '0) begin
            if (play_mode == MODE_REPEAT) cmd.kind = MSG_END;
            clear_tracking();
          end
        end else begin
          chord_acc[0] |= click1_mask;
          chord_acc[1] |= hold1_mask;
          chord_acc[2] |= click2_mask;
          chord_acc[3] |= hold2_mask;
          if ((click1_mask | hold1_mask | click2_mask | hold2_mask) != '0) gathering = 1'b1;
          if (gathering && pend_mask == '0) begin
            if (chord_acc[0] == '0 && chord_acc[1] == '0 && $onehot(chord_acc[2]) &&
                chord_acc[3] == '0) begin
              // lone double click is dropped without a message
              clear_tracking();
            end else begin
              // double events fold into the single ones
              clicks = chord_acc[0] | chord_acc[2];
              holds = chord_acc[1] | chord_acc[3];
              chord_acc[0] = clicks;
              chord_acc[1] = holds;
              hold = (holds != '0);
              chord = hold ? (clicks | holds) : clicks;
              for (int i = 0; i < 8; i++)
                if (cmd.anim == ANIM_NONE && chord == (8'd1 << i)) cmd.anim = ANIM_W'(i + 1);
              if (cmd.anim == ANIM_NONE && chord == nine_sel) cmd.anim = ANIM_NINE;
              if (cmd.anim == ANIM_NONE && chord == ten_sel) cmd.anim = ANIM_TEN;
              if (cmd.anim != ANIM_NONE) begin
                if (hold) begin
                  cmd.kind = MSG_PLAY_REPEAT;
                  play_mode = MODE_REPEAT;
                end else begin
                  cmd.kind = MSG_PLAY_ONCE;
                  clear_tracking();
                end
              end else if (hold) begin
                play_mode = MODE_WAIT;
              end else begin
                clear_tracking();
              end
            end
          end
        end
        click1_mask = '0;
        click2_mask = '0;
      end
      ACT_PRESS: pend_mask |= btn;
      ACT_SINGLE_CLICK: begin
        pend_mask &= ~btn;
        click1_mask |= btn;
      end
      ACT_SINGLE_HOLD: begin
        pend_mask &= ~btn;
        hold1_mask |= btn;
      end
      ACT_DOUBLE_CLICK: begin
        pend_mask &= ~btn;
        click2_mask |= btn;
      end
      ACT_DOUBLE_HOLD: begin
        pend_mask &= ~btn;
        hold2_mask |= btn;
      end
      ACT_HOLD_END: begin
        hold1_mask &= ~btn;
        hold2_mask &= ~btn;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predict on every input transaction, check every result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    command_t cmd;
    command_t want;
    if (rst_n && in_tvalid && in_tready) begin
      predict_command(in_tdata[2:0], in_tdata[5:3], cmd);
      expected_commands.push_back(cmd);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_commands.size() == 0) begin
        $display("%0t: unexpected result transaction, actual kind %0d anim %0d",
                 $time, out_tdata[1:0], out_tdata[5:2]);
        error_count++;
      end else begin
        want = expected_commands.pop_front();
        if (out_tdata[1:0] != want.kind) begin
          $display("%0t: message_kind expected %0d actual %0d",
                   $time, want.kind, out_tdata[1:0]);
          error_count++;
        end
        if (out_tdata[5:2] != want.anim) begin
          $display("%0t: anim_index expected %0d actual %0d",
                   $time, want.anim, out_tdata[5:2]);
          error_count++;
        end
      end
    end
  end

  // result side: random stalls, a forced hold-off when stall_left is loaded
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready = quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, called at a falling edge and returning at one
  // ---------------------------------------------------------------------------
  task automatic send_event(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {2'b00, idx, act};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // every expected command back, then a pause for the pipeline
  task automatic wait_drained();
    while (expected_commands.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_chord_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_CHORD_NINE) nine_sel = value;
    else ten_sel = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one gesture: optional presses, a click or hold per button, ticks, releases
  task automatic play_random_chord();
    logic [7:0]       mask;
    logic [7:0]       held;
    logic [ACT_W-1:0] ev;
    int               pick;
    pick = $urandom_range(9);
    held = '0;
    if (pick < 4) mask = 8'd1 << $urandom_range(7);
    else if (pick == 4) mask = nine_sel;
    else if (pick == 5) mask = ten_sel;
    else mask = 8'($urandom_range(255));
    for (int b = 0; b < 8; b++) begin
      if (mask[b]) begin
        if ($urandom_range(1)) send_event(ACT_PRESS, b[2:0]);
        // a tick while a press is still outstanding
        if ($urandom_range(3) == 0) send_event(ACT_TICK, IDX_W'($urandom_range(7)));
        ev = ACT_W'($urandom_range(ACT_DOUBLE_HOLD, ACT_SINGLE_CLICK));
        send_event(ev, b[2:0]);
        if (ev == ACT_SINGLE_HOLD || ev == ACT_DOUBLE_HOLD) held[b] = 1'b1;
      end
    end
    send_event(ACT_TICK, IDX_W'($urandom_range(7)));
    for (int b = 0; b < 8; b++) begin
      // now and then a hold is never released
      if (held[b] && $urandom_range(9) != 0) send_event(ACT_HOLD_END, b[2:0]);
      if (held[b] && $urandom_range(3) == 0) send_event(ACT_TICK, IDX_W'($urandom_range(7)));
    end
    send_event(ACT_TICK, IDX_W'($urandom_range(7)));
    send_event(ACT_TICK, IDX_W'($urandom_range(7)));
  endtask

  // mostly gestures, the rest loose events of any code
  task automatic run_random_traffic(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_event(ACT_W'($urandom_range(7)), IDX_W'($urandom_range(7)));
      end else begin
        play_random_chord();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_chords();
    // press then click on button 0: play once, animation 1
    send_event(ACT_PRESS, 3'd0);
    send_event(ACT_SINGLE_CLICK, 3'd0);
    send_event(ACT_TICK, 3'd0);
    // click with no press announced, top button
    send_event(ACT_SINGLE_CLICK, 3'd7);
    send_event(ACT_TICK, 3'd0);
    // lone double click is swallowed
    send_event(ACT_DOUBLE_CLICK, 3'd3);
    send_event(ACT_TICK, 3'd0);
    // hold plus double hold on buttons 0 and 1: repeat nine, end on release
    send_event(ACT_SINGLE_HOLD, 3'd0);
    send_event(ACT_DOUBLE_HOLD, 3'd1);
    send_event(ACT_TICK, 3'd0);
    send_event(ACT_HOLD_END, 3'd0);
    send_event(ACT_HOLD_END, 3'd1);
    send_event(ACT_TICK, 3'd0);
    // click plus double click on 0 and 7: play once ten
    send_event(ACT_SINGLE_CLICK, 3'd0);
    send_event(ACT_DOUBLE_CLICK, 3'd7);
    send_event(ACT_TICK, 3'd0);
    // hold with no matching chord: wait for release, no message
    send_event(ACT_SINGLE_HOLD, 3'd2);
    send_event(ACT_SINGLE_CLICK, 3'd5);
    send_event(ACT_TICK, 3'd0);
    send_event(ACT_HOLD_END, 3'd2);
    send_event(ACT_TICK, 3'd0);
    // chord held back by a pending press until its click comes
    send_event(ACT_PRESS, 3'd4);
    send_event(ACT_TICK, 3'd0);
    send_event(ACT_SINGLE_CLICK, 3'd4);
    send_event(ACT_TICK, 3'd0);
    // unused action code, tick with a nonzero index
    send_event(ACT_UNUSED, 3'd7);
    send_event(ACT_TICK, 3'd7);
  endtask

  task automatic test_register_extremes();
    // nine never matches, ten takes all buttons
    write_chord_reg(REG_CHORD_NINE, 8'h00);
    write_chord_reg(REG_CHORD_TEN, 8'hff);
    for (int b = 0; b < 8; b++) send_event(ACT_SINGLE_CLICK, b[2:0]);
    send_event(ACT_TICK, 3'd0);
    run_random_traffic(200);
    // all buttons held selects nine
    write_chord_reg(REG_CHORD_NINE, 8'hff);
    write_chord_reg(REG_CHORD_TEN, 8'h00);
    for (int b = 0; b < 8; b++) send_event(ACT_SINGLE_HOLD, b[2:0]);
    send_event(ACT_TICK, 3'd0);
    for (int b = 0; b < 8; b++) send_event(ACT_HOLD_END, b[2:0]);
    send_event(ACT_TICK, 3'd0);
    run_random_traffic(150);
    // one-hot register value loses against the single-button animation
    write_chord_reg(REG_CHORD_NINE, 8'h10);
    write_chord_reg(REG_CHORD_TEN, CFG_W'($urandom_range(255)));
    run_random_traffic(150);
  endtask

  task automatic test_random_traffic();
    write_chord_reg(REG_CHORD_NINE, CHORD_NINE_RST);
    write_chord_reg(REG_CHORD_TEN, CHORD_TEN_RST);
    run_random_traffic(250);
    write_chord_reg(REG_CHORD_NINE, CFG_W'($urandom_range(255)));
    write_chord_reg(REG_CHORD_TEN, CFG_W'($urandom_range(255)));
    run_random_traffic(150);
  endtask

  task automatic test_backpressure();
    // no idling on either side, and a long receiver hold-off at the start
    quiet = 1'b1;
    @(posedge clk);
    stall_left = 80;
    @(negedge clk);
    run_random_traffic(200);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_chords();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
